// File: sv/cylindrical_gradient_shader_top_macros.svh
// ----------------------------------------------------------------------------
// cylindrical gradient shader assertion macros
// shared property wrappers clocked on clk, with and without reset masking
// ----------------------------------------------------------------------------
`ifndef CYLINDRICAL_GRADIENT_SHADER_TOP_MACROS_SVH
`define CYLINDRICAL_GRADIENT_SHADER_TOP_MACROS_SVH

// property checked outside reset
`define CGS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define CGS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/cgs_pkg.sv
// ----------------------------------------------------------------------------
// cgs_pkg
// shared constants, types and the cordic angle table of the gradient shader
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int ANGLE_BITS_DEFAULT = 16;

  // cordic datapath width, enough for 2^31 inputs times the cordic gain
  localparam int XW = 36;

  // twist divider: remainder width and divisor
  localparam int          REM_W   = 10;
  localparam logic [10:0] TWIST_DIV = 11'd1000;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_NEAR_COLOR   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAR_COLOR    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_COUNT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SWIRL_ENABLE = 3'd3;

  localparam logic [23:0] NEAR_COLOR_RESET  = 24'h000000;
  localparam logic [23:0] FAR_COLOR_RESET   = 24'hFFFFFF;
  localparam logic [15:0] CYCLE_COUNT_RESET = 16'd256;

  typedef struct packed {
    logic origin;   // x and z both zero
    logic y_neg;    // twist dividend was negative
  } cgs_flags_t;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic [31:0] turn_angle(input int i);
    logic [31:0] t;
    unique case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2F9;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      23: t = 32'h00000051;
      24: t = 32'h00000029;
      25: t = 32'h00000014;
      26: t = 32'h0000000A;
      27: t = 32'h00000005;
      28: t = 32'h00000003;
      29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

// File: sv/cgs_front.sv
// ----------------------------------------------------------------------------
// cgs_front
// input stage: half-turn pre-rotation, origin detect, twist dividend setup
// ----------------------------------------------------------------------------
module cgs_front import cgs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
  parameter int DB         = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic signed [31:0]     point_x,
  input  logic signed [31:0]     point_y,
  input  logic signed [31:0]     point_z,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic signed [XW-1:0]   x,
  output logic signed [XW-1:0]   z,
  output logic [31:0]            acc,
  output cgs_flags_t             flags,
  output logic [DB-1:0]          w
);

  localparam int SH_L = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
  localparam int SH_R = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam int UW   = 32 + SH_L;

  logic signed [XW-1:0] x_ext, z_ext, x_next, z_next;
  logic [31:0]          acc_next;
  logic signed [UW-1:0] y_ext, u;
  logic [UW-1:0]        u_mag;
  cgs_flags_t           flags_next;
  logic                 load;

  assign up_ready = !dn_valid || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    x_ext = XW'(point_x);
    z_ext = XW'(point_z);
    // left half plane: turn by half a turn so the cordic sees x >= 0
    if (point_x[31]) begin
      x_next   = -x_ext;
      z_next   = -z_ext;
      acc_next = HALF_TURN;
    end else begin
      x_next   = x_ext;
      z_next   = z_ext;
      acc_next = '0;
    end
    // y scaled to 2^-ANGLE_BITS units of y/1000, floored, before the divide
    y_ext = UW'(point_y);
    u     = (y_ext <<< SH_L) >>> SH_R;
    // negative dividend: floor(u/d) = ~floor(~u/d)
    u_mag = u[UW-1] ? ~u : u;
    flags_next.origin = (point_x == 32'sd0) && (point_z == 32'sd0);
    flags_next.y_neg  = u[UW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x     <= x_next;
      z     <= z_next;
      acc   <= acc_next;
      flags <= flags_next;
      w     <= DB'(u_mag[UW-2:0]);
    end
  end

endmodule

// File: sv/cgs_cell.sv
// ----------------------------------------------------------------------------
// cgs_cell
// one cordic vectoring step plus BPC bits of the twist divide by 1000
// ----------------------------------------------------------------------------
module cgs_cell import cgs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
  parameter int STAGE      = 0,
  parameter int DB         = 32,
  parameter int BPC        = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic signed [XW-1:0]   x_in,
  input  logic signed [XW-1:0]   z_in,
  input  logic [31:0]            acc_in,
  input  cgs_flags_t             flags_in,
  input  logic [DB-1:0]          w_in,
  input  logic [REM_W-1:0]       r_in,
  input  logic [ANGLE_BITS-1:0]  q_in,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic signed [XW-1:0]   x_out,
  output logic signed [XW-1:0]   z_out,
  output logic [31:0]            acc_out,
  output cgs_flags_t             flags_out,
  output logic [DB-1:0]          w_out,
  output logic [REM_W-1:0]       r_out,
  output logic [ANGLE_BITS-1:0]  q_out
);

  localparam logic [31:0] TURN = turn_angle(STAGE);

  logic signed [XW-1:0] dx, dz, x_next, z_next;
  logic [31:0]          acc_next;
  logic [DB-1:0]        w_c;
  logic [REM_W-1:0]     r_c;
  logic [REM_W:0]       r2;
  logic [ANGLE_BITS-1:0] q_c;
  logic                 ge;
  logic                 load;

  assign up_ready = !dn_valid || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    dx = z_in >>> STAGE;
    dz = x_in >>> STAGE;
    if (!z_in[XW-1]) begin
      x_next   = x_in + dx;
      z_next   = z_in - dz;
      acc_next = acc_in + TURN;
    end else begin
      x_next   = x_in - dx;
      z_next   = z_in + dz;
      acc_next = acc_in - TURN;
    end
  end

  // restoring division, msb first, only the low quotient bits are kept
  always_comb begin
    w_c = w_in;
    r_c = r_in;
    q_c = q_in;
    r2  = '0;
    ge  = 1'b0;
    for (int b = 0; b < BPC; b++) begin
      r2  = {r_c, w_c[DB-1]};
      w_c = {w_c[DB-2:0], 1'b0};
      ge  = (r2 >= TWIST_DIV);
      r_c = ge ? REM_W'(r2 - TWIST_DIV) : r2[REM_W-1:0];
      q_c = {q_c[ANGLE_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_out     <= x_next;
      z_out     <= z_next;
      acc_out   <= acc_next;
      flags_out <= flags_in;
      w_out     <= w_c;
      r_out     <= r_c;
      q_out     <= q_c;
    end
  end

endmodule

// File: sv/cgs_back.sv
// ----------------------------------------------------------------------------
// cgs_back
// angle rounding, twist add, repeat scaling, triangle fold and colour blend
// ----------------------------------------------------------------------------
module cgs_back import cgs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [31:0]           acc,
  input  cgs_flags_t            flags,
  input  logic [ANGLE_BITS-1:0] quot,
  input  logic [23:0]           near_color,
  input  logic [23:0]           far_color,
  input  logic [15:0]           cycle_count,
  input  logic                  swirl_enable,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue
);

  localparam int PW = ANGLE_BITS + 16;
  localparam int VW = ANGLE_BITS + 1;
  localparam int NW = ANGLE_BITS + 11;
  localparam logic [31:0]   ROUND_A = 32'(64'd1 << (31 - ANGLE_BITS));
  localparam logic [VW-1:0] ONE     = VW'(64'd1 << ANGLE_BITS);
  localparam logic [NW-1:0] ROUND_B = NW'(64'd1 << (ANGLE_BITS - 1));

  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input logic [VW-1:0] v);
    logic signed [8:0]    diff;
    logic signed [NW-1:0] num;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    num  = $signed({3'b000, a, {ANGLE_BITS{1'b0}}}) + diff * $signed({1'b0, v})
           + $signed(ROUND_B);
    return num[ANGLE_BITS+7:ANGLE_BITS];
  endfunction

  logic                  valid_a;
  logic                  ready_a;
  logic [PW-1:0]         prod;
  logic [31:0]           acc_rnd;
  logic [ANGLE_BITS-1:0] ang, twist, ang_sw;
  logic [ANGLE_BITS-1:0] frac;
  logic [VW-1:0]         val;

  assign ready_a  = !dn_valid || dn_ready;
  assign up_ready = !valid_a || ready_a;

  always_comb begin
    acc_rnd = acc + ROUND_A;
    ang     = flags.origin ? '0 : acc_rnd[31 -: ANGLE_BITS];
    twist   = flags.y_neg ? ~quot : quot;
    ang_sw  = swirl_enable ? ang + twist : ang;
  end

  // odd repeat segments run backwards
  always_comb begin
    frac = prod[ANGLE_BITS+7:8];
    val  = prod[ANGLE_BITS+8] ? ONE - {1'b0, frac} : {1'b0, frac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a  <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        valid_a <= up_valid;
      end
      if (ready_a) begin
        dn_valid <= valid_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      prod <= PW'(ang_sw) * PW'(cycle_count);
    end
    if (valid_a && ready_a) begin
      red   <= blend(near_color[23:16], far_color[23:16], val);
      green <= blend(near_color[15:8],  far_color[15:8],  val);
      blue  <= blend(near_color[7:0],   far_color[7:0],   val);
    end
  end

endmodule

// File: sv/cylindrical_gradient_shader_top.sv
// ----------------------------------------------------------------------------
// cylindrical gradient shader
// input stage, ANGLE_BITS+4 cordic cells, scale stage and blend stage;
// one point per cycle sustained while the output is not stalled.
// each stage holds its item only while the next one is full and stalled.
// reset empties the pipeline and loads the default colours and count.
// ----------------------------------------------------------------------------
module cylindrical_gradient_shader_top import cgs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [31:0]     point_x,
  input  logic signed [31:0]     point_y,
  input  logic signed [31:0]     point_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int STEPS = ANGLE_BITS + 4;
  localparam int WB    = 31 + ((ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0);
  localparam int BPC   = (WB + STEPS - 1) / STEPS;
  localparam int DB    = BPC * STEPS;

  logic [23:0] near_color, far_color;
  logic [15:0] cycle_count;
  logic        swirl_enable;

  logic                  v_s   [STEPS+1];
  logic                  rdy_s [STEPS+1];
  logic signed [XW-1:0]  x_s   [STEPS+1];
  logic signed [XW-1:0]  z_s   [STEPS+1];
  logic [31:0]           acc_s [STEPS+1];
  cgs_flags_t            fl_s  [STEPS+1];
  logic [DB-1:0]         w_s   [STEPS+1];
  logic [REM_W-1:0]      r_s   [STEPS+1];
  logic [ANGLE_BITS-1:0] q_s   [STEPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_color   <= NEAR_COLOR_RESET;
      far_color    <= FAR_COLOR_RESET;
      cycle_count  <= CYCLE_COUNT_RESET;
      swirl_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NEAR_COLOR:   near_color   <= cfg_data[23:0];
        REG_FAR_COLOR:    far_color    <= cfg_data[23:0];
        REG_CYCLE_COUNT:  cycle_count  <= cfg_data[15:0];
        REG_SWIRL_ENABLE: swirl_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cgs_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .DB         (DB)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .dn_valid (v_s[0]),
    .dn_ready (rdy_s[0]),
    .x        (x_s[0]),
    .z        (z_s[0]),
    .acc      (acc_s[0]),
    .flags    (fl_s[0]),
    .w        (w_s[0])
  );

  // divider starts empty
  assign r_s[0] = '0;
  assign q_s[0] = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    cgs_cell #(
      .ANGLE_BITS (ANGLE_BITS),
      .STAGE      (i),
      .DB         (DB),
      .BPC        (BPC)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (v_s[i]),
      .up_ready  (rdy_s[i]),
      .x_in      (x_s[i]),
      .z_in      (z_s[i]),
      .acc_in    (acc_s[i]),
      .flags_in  (fl_s[i]),
      .w_in      (w_s[i]),
      .r_in      (r_s[i]),
      .q_in      (q_s[i]),
      .dn_valid  (v_s[i+1]),
      .dn_ready  (rdy_s[i+1]),
      .x_out     (x_s[i+1]),
      .z_out     (z_s[i+1]),
      .acc_out   (acc_s[i+1]),
      .flags_out (fl_s[i+1]),
      .w_out     (w_s[i+1]),
      .r_out     (r_s[i+1]),
      .q_out     (q_s[i+1])
    );
  end

  cgs_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (v_s[STEPS]),
    .up_ready     (rdy_s[STEPS]),
    .acc          (acc_s[STEPS]),
    .flags        (fl_s[STEPS]),
    .quot         (q_s[STEPS]),
    .near_color   (near_color),
    .far_color    (far_color),
    .cycle_count  (cycle_count),
    .swirl_enable (swirl_enable),
    .dn_valid     (out_valid),
    .dn_ready     (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

endmodule

// File: sv/cgs_checker.sv
// ----------------------------------------------------------------------------
// cgs_checker
// port level checks on the shader output channel and pipeline back-pressure
// ----------------------------------------------------------------------------
`include "cylindrical_gradient_shader_top_macros.svh"

module cgs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // a result waiting for its transaction keeps its colour
  `CGS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable({red, green, blue}), "output changed while stalled")

  // reset leaves no result behind
  `CGS_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result present after reset")

  // input is refused only when the whole pipeline is full behind a stalled output
  `CGS_ASSERT(a_no_false_stall, !in_ready |-> out_valid && !out_ready, "input stalled with room in pipeline")

  // an input transaction while the output drains must not be refused
  `CGS_ASSERT(a_accept_on_drain, in_valid && out_ready |-> in_ready, "input refused while output drains")

endmodule

bind cylindrical_gradient_shader_top cgs_checker u_cgs_checker (.*);

// File: test/cylindrical_gradient_shader_top_tb.sv
// ----------------------------------------------------------------------------
// cylindrical gradient shader testbench
// streams 3d points through the shader under random source gaps and sink
// stalls, predicts every shaded colour with an independent cordic, twist and
// blend model, and compares the colours in order across several register
// settings
// ----------------------------------------------------------------------------
module cylindrical_gradient_shader_top_tb;
  import cgs_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_POINTS   = 78;

  // index with no register behind it, writes must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd5;

  localparam int          TURN_STEPS   = 20;
  localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
  localparam longint      TWIST_STEP   = 64'd65536000;
  localparam logic [16:0] BLEND_ONE    = 17'h10000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN [TURN_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } shade_t;

  class shade_scoreboard;
    logic [23:0] near_rgb;
    logic [23:0] far_rgb;
    logic [15:0] repeats;
    logic        twist_on;
    shade_t      expected_colours[$];
    int          errors;

    function new();
      near_rgb = 24'h000000;
      far_rgb  = 24'hFFFFFF;
      repeats  = 16'd256;
      twist_on = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_NEAR_COLOR:   near_rgb = data[23:0];
        REG_FAR_COLOR:    far_rgb  = data[23:0];
        REG_CYCLE_COUNT:  repeats  = data[15:0];
        REG_SWIRL_ENABLE: twist_on = data[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] blend(logic [7:0] a, logic [7:0] b, logic [16:0] v);
      logic [31:0] num;
      num = {24'd0, a} * ({15'd0, BLEND_ONE} - {15'd0, v}) + {24'd0, b} * {15'd0, v}
            + 32'h8000;
      return num[23:16];
    endfunction

    // work out the colour this point should shade to
    function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      longint      cx, cz, dx, dz, t, q;
      logic [31:0] acc;
      logic [32:0] rounded;
      logic [15:0] ang, frac;
      logic [31:0] prod;
      logic [16:0] v;
      shade_t      c;
      cx = x;
      cz = z;
      ang = '0;
      if (cx != 0 || cz != 0) begin
        acc = '0;
        if (cx < 0) begin
          cx  = -cx;
          cz  = -cz;
          acc = TURN_HALF;
        end
        for (int i = 0; i < TURN_STEPS; i++) begin
          dx = cz >>> i;
          dz = cx >>> i;
          if (cz >= 0) begin
            cx  = cx + dx;
            cz  = cz - dz;
            acc = acc + ATAN_TURN[i];
          end else begin
            cx  = cx - dx;
            cz  = cz + dz;
            acc = acc - ATAN_TURN[i];
          end
        end
        // round half up, a full turn wraps to zero
        rounded = {1'b0, acc} + 33'h8000;
        ang = rounded[31:16];
      end
      if (twist_on) begin
        t = longint'(y) * 64'sd65536;
        if (t >= 0) q = t / TWIST_STEP;
        else q = -((-t + TWIST_STEP - 1) / TWIST_STEP);
        ang = ang + q[15:0];
      end
      prod = {16'd0, ang} * {16'd0, repeats};
      frac = prod[23:8];
      // odd segment mirrors the fraction
      v = prod[24] ? BLEND_ONE - {1'b0, frac} : {1'b0, frac};
      c.red   = blend(near_rgb[23:16], far_rgb[23:16], v);
      c.green = blend(near_rgb[15:8], far_rgb[15:8], v);
      c.blue  = blend(near_rgb[7:0], far_rgb[7:0], v);
      expected_colours.push_back(c);
    endfunction

    function void check_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      shade_t e;
      if (expected_colours.size() == 0) begin
        $error("colour transaction with nothing expected: %0d %0d %0d", r, g, b);
        errors++;
      end else begin
        e = expected_colours.pop_front();
        if (r !== e.red) begin
          $error("red: expected %0d, got %0d", e.red, r);
          errors++;
        end
        if (g !== e.green) begin
          $error("green: expected %0d, got %0d", e.green, g);
          errors++;
        end
        if (b !== e.blue) begin
          $error("blue: expected %0d, got %0d", e.blue, b);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_colours.size();
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic signed [31:0]     point_x   = '0;
  logic signed [31:0]     point_y   = '0;
  logic signed [31:0]     point_z   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic idle_on    = 1'b1;
  int   stall_left = 0;
  int   cycle_total = 0;

  shade_scoreboard sb = new();

  cylindrical_gradient_shader_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_total <= cycle_total + 1;
    if (cycle_total >= TIMEOUT_CYCLES) begin
      $display("cylindrical_gradient_shader_top regression: fail");
      $finish;
    end
  end

  // sink: check each colour transaction, stall in short random bursts while idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) sb.check_colour(red, green, blue);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid is left high on return so back-to-back points need no lowering
  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x  <= x;
    point_y  <= y;
    point_z  <= z;
    do @(posedge clk); while (!in_ready);
    sb.note_point(x, y, z);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, data);
  endtask

  // upper data bits are junk and must be masked by the block
  task automatic configure(input logic [23:0] near_rgb, input logic [23:0] far_rgb,
                           input logic [15:0] repeats, input logic twist);
    write_reg(REG_NEAR_COLOR, near_rgb);
    write_reg(REG_FAR_COLOR, far_rgb);
    write_reg(REG_CYCLE_COUNT, {8'($urandom), repeats});
    write_reg(REG_SWIRL_ENABLE, {23'($urandom), twist});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    logic [31:0] r;
    int          k;
    r = $urandom;
    case ($urandom_range(0, 7))
      0, 1: return r;
      2:    return $urandom_range(0, 4000) - 2000;
      3:    return 32'd0;
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      5:    return {{12{r[19]}}, r[19:0]};
      // just either side of a whole twist step
      6: begin
        k = int'($urandom_range(0, 64)) - 32;
        return 32'(k * 65536000 + int'($urandom_range(0, 2)) - 1);
      end
      default: return r & 32'hFFFF_0000;
    endcase
  endfunction

  function automatic logic [23:0] rand_rgb();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] rand_repeats();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd256;
      3: return 16'($urandom_range(1, 1024));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // geometry at the reset settings
    send_point(32'sd0, 32'sd0, 32'sd0);
    send_point(32'sd65536, 32'sd0, 32'sd0);
    send_point(-32'sd65536, 32'sd0, 32'sd0);
    send_point(32'sd0, 32'sd0, 32'sd65536);
    send_point(32'sd0, 32'sd0, -32'sd65536);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'sd0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'sd0);
    send_point(32'sd0, 32'sd0, 32'h7FFF_FFFF);
    send_point(32'sd0, 32'sd0, 32'h8000_0000);
    send_point(32'h8000_0000, 32'sd0, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'sd0, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'sd0, 32'h8000_0000);
    send_point(32'h8000_0000, 32'sd0, 32'h7FFF_FFFF);
    // just below a full turn, rounds back to zero
    send_point(32'h7FFF_FFFF, 32'sd0, -32'sd1);
    send_point(-32'sd1, 32'sd0, 32'sd0);
    send_point(32'sd1, 32'sd0, -32'sd1);
    drain();

    // zero repeat count gives the near colour
    configure(rand_rgb(), rand_rgb(), 16'h0000, 1'b0);
    send_point(rand_coord(), rand_coord(), rand_coord());
    send_point(32'sd123456, 32'sd0, -32'sd98765);
    drain();

    configure(24'hFFFFFF, 24'h000000, 16'hFFFF, 1'b1);
    write_reg(REG_SPARE, 24'hFFFFFF);
    cfg_valid <= 1'b0;
    send_point(32'sd65536, 32'h7FFF_FFFF, 32'sd0);
    send_point(32'sd65536, 32'h8000_0000, 32'sd0);
    send_point(32'sd65536, 32'sd65536000, 32'sd0);
    send_point(32'sd65536, -32'sd65536000, 32'sd0);
    send_point(32'sd65536, -32'sd1, 32'sd0);
    send_point(-32'sd1, 32'h7FFF_FFFF, -32'sd1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on <= (p != RANDOM_PHASES - 1) && (p % 3 != 2);
      configure(rand_rgb(), rand_rgb(), rand_repeats(), 1'($urandom_range(0, 1)));
      for (int n = 0; n < PHASE_POINTS; n++) begin
        // hold the source until the pipeline has emptied
        if (p == 3 && n == PHASE_POINTS / 2) drain();
        send_point(rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("cylindrical_gradient_shader_top regression: pass");
    end else begin
      $display("cylindrical_gradient_shader_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/cgs_pkg.sv
sv/cgs_front.sv
sv/cgs_cell.sv
sv/cgs_back.sv
sv/cylindrical_gradient_shader_top.sv
sv/cgs_checker.sv
test/cylindrical_gradient_shader_top_tb.sv
